>>> hdl/alfl_pkg.sv
// ============================================================================
// alfl_pkg: shared types, codes and microcode for the linked record pool
// Holds the item structs, the operation codes and the read-only control
// program that sequences insert, delete and lookup.
// ============================================================================
package alfl_pkg;

  // Operation codes carried in the mode field of a command item.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam int unsigned KeyFieldW  = 32;
  localparam int unsigned PayFieldW  = 64;
  localparam int unsigned SlotFieldW = 6;

  typedef struct packed {
    logic [1:0]           mode;
    logic [KeyFieldW-1:0] key;
    logic [PayFieldW-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic                  failed;
    logic [KeyFieldW-1:0]  found_key;
    logic [PayFieldW-1:0]  found_payload;
    logic [SlotFieldW-1:0] slot_index;
  } res_t;

  // Microprogram addresses.
  typedef logic [3:0] upc_t;
  localparam upc_t U_IDLE  = 4'd0;
  localparam upc_t U_INS0  = 4'd1;
  localparam upc_t U_INS1  = 4'd2;
  localparam upc_t U_INS2  = 4'd3;
  localparam upc_t U_WALK0 = 4'd4;
  localparam upc_t U_WALK1 = 4'd5;
  localparam upc_t U_MATCH = 4'd6;
  localparam upc_t U_LKP   = 4'd7;
  localparam upc_t U_DEL0  = 4'd8;
  localparam upc_t U_DEL1  = 4'd9;
  localparam upc_t U_FAIL  = 4'd10;

  // Branch conditions of a control word.
  typedef enum logic [2:0] {
    C_SEQ,
    C_JUMP,
    C_DISPATCH,
    C_FREE_NULL,
    C_HEAD_NULL,
    C_WALK,
    C_IS_DEL
  } cond_e;

  // Datapath operations of a control word.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_INS_ALLOC,
    OP_INS_POP,
    OP_INS_LINK,
    OP_WALK_START,
    OP_WALK,
    OP_DEL_UNLINK,
    OP_DEL_FREE
  } op_e;

  // Result emitted by a control word.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_FAIL
  } res_e;

  typedef struct packed {
    cond_e cond;
    upc_t  tgt;
    op_e   op;
    res_e  res;
  } uword_t;

  // The control program: one word per step.
  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    w = '{cond: C_JUMP, tgt: U_IDLE, op: OP_NONE, res: RES_NONE};
    case (upc)
      U_IDLE:  w = '{cond: C_DISPATCH,  tgt: U_IDLE,  op: OP_LATCH,      res: RES_NONE};
      U_INS0:  w = '{cond: C_FREE_NULL, tgt: U_FAIL,  op: OP_INS_ALLOC,  res: RES_NONE};
      U_INS1:  w = '{cond: C_SEQ,       tgt: U_IDLE,  op: OP_INS_POP,    res: RES_NONE};
      U_INS2:  w = '{cond: C_JUMP,      tgt: U_IDLE,  op: OP_INS_LINK,   res: RES_OK};
      U_WALK0: w = '{cond: C_HEAD_NULL, tgt: U_FAIL,  op: OP_WALK_START, res: RES_NONE};
      U_WALK1: w = '{cond: C_WALK,      tgt: U_MATCH, op: OP_WALK,       res: RES_NONE};
      U_MATCH: w = '{cond: C_IS_DEL,    tgt: U_DEL0,  op: OP_NONE,       res: RES_NONE};
      U_LKP:   w = '{cond: C_JUMP,      tgt: U_IDLE,  op: OP_NONE,       res: RES_OK};
      U_DEL0:  w = '{cond: C_SEQ,       tgt: U_IDLE,  op: OP_DEL_UNLINK, res: RES_NONE};
      U_DEL1:  w = '{cond: C_JUMP,      tgt: U_IDLE,  op: OP_DEL_FREE,   res: RES_OK};
      U_FAIL:  w = '{cond: C_JUMP,      tgt: U_IDLE,  op: OP_NONE,       res: RES_FAIL};
      default: w = '{cond: C_JUMP,      tgt: U_IDLE,  op: OP_NONE,       res: RES_NONE};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/alfl_ram.sv
// ============================================================================
// alfl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module alfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/array_linked_list_with_free_list.sv
// ============================================================================
// array_linked_list_with_free_list: linked record pool with a free list
// Insert at tail, delete by key and lookup by key over a fixed slot pool,
// run by a small microprogram over a link RAM and a record RAM.
// ============================================================================
// A command item is taken when start is high and busy is low; busy then stays
// high until the cycle in which the item's single result is shown. The result
// appears on res_o for exactly one cycle with done_o high and must be captured
// in that cycle, since the block cannot be held off. An insert allocates the
// free head, pops it off the free chain and links it behind the tail. A
// delete or lookup follows one list slot per cycle through the link RAM's
// registered read port up to the first record with the key, and fails when
// it reaches the end of the list; an empty list fails without a walk. A new
// item can be accepted in the cycle in which the previous result is shown.
// No clearing pass is needed after reset: slots never handed out are tracked
// by a fill count, and their reset links are produced from it.
module array_linked_list_with_free_list #(
  parameter int unsigned POOL_DEPTH   = 64,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  alfl_pkg::cmd_t  cmd_i,
  output logic            done_o,
  output alfl_pkg::res_t  res_o
);

  // Slot numbers run 0 .. POOL_DEPTH-1; a link of POOL_DEPTH means null.
  localparam int unsigned SlotW = $clog2(POOL_DEPTH);
  localparam int unsigned LinkW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned RecW  = KEY_BITS + PAYLOAD_BITS;
  localparam logic [LinkW-1:0] Nil = LinkW'(POOL_DEPTH);

  // Sequencer.
  alfl_pkg::upc_t   upc_q, upc_d;
  alfl_pkg::uword_t uw;

  // List bookkeeping (control state, cleared by reset).
  logic [LinkW-1:0] free_head_q, head_q, tail_q, fresh_q;
  logic             done_q;

  // Working registers for the item in flight.
  logic [1:0]              mode_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [LinkW-1:0]        cur_q, prev_q, nxt_q;
  logic [KEY_BITS-1:0]     fkey_q;
  logic [PAYLOAD_BITS-1:0] fpay_q;
  alfl_pkg::res_t          res_q;

  // RAM ports.
  logic             link_we;
  logic [SlotW-1:0] link_waddr;
  logic [LinkW-1:0] link_wdata;
  logic [LinkW-1:0] link_rdata;
  logic             rec_we;
  logic [RecW-1:0]  rec_rdata;
  logic [SlotW-1:0] raddr;

  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                    key_hit;
  logic [LinkW-1:0]        link_eff;

  assign uw      = alfl_pkg::ucode(upc_q);
  assign busy    = (upc_q != alfl_pkg::U_IDLE);
  assign rd_key  = rec_rdata[PAYLOAD_BITS +: KEY_BITS];
  assign rd_pay  = rec_rdata[PAYLOAD_BITS-1:0];
  assign key_hit = (rd_key == key_q);

  // A slot at or above the fill count was never allocated, so its link still
  // holds the reset chain value: the next slot, or null for the last one.
  assign link_eff = (cur_q >= fresh_q) ? (cur_q + LinkW'(1)) : link_rdata;

  // Next microprogram address.
  always_comb begin
    upc_d = upc_q;
    case (uw.cond)
      alfl_pkg::C_SEQ:  upc_d = upc_q + 4'd1;
      alfl_pkg::C_JUMP: upc_d = uw.tgt;
      alfl_pkg::C_DISPATCH: begin
        if (start) begin
          case (cmd_i.mode)
            alfl_pkg::MODE_INSERT: upc_d = alfl_pkg::U_INS0;
            alfl_pkg::MODE_DELETE,
            alfl_pkg::MODE_LOOKUP: upc_d = alfl_pkg::U_WALK0;
            default:               upc_d = alfl_pkg::U_FAIL;
          endcase
        end
      end
      alfl_pkg::C_FREE_NULL: upc_d = (free_head_q == Nil) ? uw.tgt : upc_q + 4'd1;
      alfl_pkg::C_HEAD_NULL: upc_d = (head_q == Nil) ? uw.tgt : upc_q + 4'd1;
      alfl_pkg::C_WALK: begin
        // The walk stays on this step, one slot per cycle, until a hit or
        // the end of the list.
        if (key_hit) begin
          upc_d = uw.tgt;
        end else if (link_rdata == Nil) begin
          upc_d = alfl_pkg::U_FAIL;
        end else begin
          upc_d = upc_q;
        end
      end
      alfl_pkg::C_IS_DEL: upc_d = (mode_q == alfl_pkg::MODE_DELETE) ? uw.tgt : upc_q + 4'd1;
      default:            upc_d = alfl_pkg::U_IDLE;
    endcase
  end

  // RAM port control driven by the current control word.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur_q[SlotW-1:0];
    link_wdata = Nil;
    rec_we     = 1'b0;
    raddr      = cur_q[SlotW-1:0];
    case (uw.op)
      alfl_pkg::OP_INS_ALLOC: begin
        // Fetch the free head's link and store the record in that slot. A
        // full pool has no slot to write.
        raddr  = free_head_q[SlotW-1:0];
        rec_we = (free_head_q != Nil);
      end
      alfl_pkg::OP_INS_POP: begin
        link_we = 1'b1;
      end
      alfl_pkg::OP_INS_LINK: begin
        link_we    = (tail_q != Nil);
        link_waddr = tail_q[SlotW-1:0];
        link_wdata = cur_q;
      end
      alfl_pkg::OP_WALK_START: begin
        raddr = head_q[SlotW-1:0];
      end
      alfl_pkg::OP_WALK: begin
        // Fetch the following slot while the current one is compared.
        raddr = link_rdata[SlotW-1:0];
      end
      alfl_pkg::OP_DEL_UNLINK: begin
        // A middle or tail record is bypassed by its predecessor; on a tail
        // delete the successor is null, so the predecessor becomes the tail.
        link_we    = (cur_q != head_q);
        link_waddr = prev_q[SlotW-1:0];
        link_wdata = nxt_q;
      end
      alfl_pkg::OP_DEL_FREE: begin
        link_we    = 1'b1;
        link_wdata = free_head_q;
      end
      default: begin
      end
    endcase
  end

  // Control state and registered result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= alfl_pkg::U_IDLE;
      free_head_q <= '0;
      head_q      <= Nil;
      tail_q      <= Nil;
      fresh_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      upc_q  <= upc_d;
      done_q <= (uw.res != alfl_pkg::RES_NONE);
      case (uw.op)
        alfl_pkg::OP_INS_POP: begin
          free_head_q <= link_eff;
          if (cur_q >= fresh_q) begin
            fresh_q <= cur_q + LinkW'(1);
          end
        end
        alfl_pkg::OP_INS_LINK: begin
          tail_q <= cur_q;
          if (head_q == Nil) begin
            head_q <= cur_q;
          end
        end
        alfl_pkg::OP_DEL_UNLINK: begin
          if (cur_q == head_q) begin
            head_q <= nxt_q;
            if (nxt_q == Nil) begin
              tail_q <= Nil;
            end
          end else if (cur_q == tail_q) begin
            tail_q <= prev_q;
          end
        end
        alfl_pkg::OP_DEL_FREE: begin
          free_head_q <= cur_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Working data and result payload.
  always_ff @(posedge clk_i) begin
    case (uw.op)
      alfl_pkg::OP_LATCH: begin
        if (start) begin
          mode_q <= cmd_i.mode;
          key_q  <= KEY_BITS'(cmd_i.key);
          pay_q  <= PAYLOAD_BITS'(cmd_i.payload);
        end
      end
      alfl_pkg::OP_INS_ALLOC: begin
        cur_q <= free_head_q;
      end
      alfl_pkg::OP_WALK_START: begin
        cur_q  <= head_q;
        prev_q <= Nil;
      end
      alfl_pkg::OP_WALK: begin
        if (key_hit) begin
          nxt_q  <= link_rdata;
          fkey_q <= rd_key;
          fpay_q <= rd_pay;
        end else begin
          prev_q <= cur_q;
          cur_q  <= link_rdata;
        end
      end
      default: begin
      end
    endcase

    case (uw.res)
      alfl_pkg::RES_OK: begin
        res_q.failed     <= 1'b0;
        res_q.slot_index <= alfl_pkg::SlotFieldW'(cur_q);
        if (mode_q == alfl_pkg::MODE_LOOKUP) begin
          res_q.found_key     <= alfl_pkg::KeyFieldW'(fkey_q);
          res_q.found_payload <= alfl_pkg::PayFieldW'(fpay_q);
        end else begin
          res_q.found_key     <= '0;
          res_q.found_payload <= '0;
        end
      end
      alfl_pkg::RES_FAIL: begin
        res_q.failed        <= 1'b1;
        res_q.slot_index    <= '0;
        res_q.found_key     <= '0;
        res_q.found_payload <= '0;
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Next-slot links, reset chain supplied by the fill count.
  alfl_ram #(
    .WIDTH (LinkW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rdata)
  );

  // Key and payload of each slot, written on insert.
  alfl_ram #(
    .WIDTH (RecW),
    .DEPTH (POOL_DEPTH)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (free_head_q[SlotW-1:0]),
    .wdata_i ({key_q, pay_q}),
    .raddr_i (raddr),
    .rdata_o (rec_rdata)
  );

  // The block leaves its busy phase only while showing a result.
  a_busy_end_has_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result strobe");

  // Each item yields one result, so strobes never come back to back.
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The fill count never passes the pool size.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= Nil)
    else $error("fill count beyond pool size");

  // A failed result carries no slot and no record.
  a_fail_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.failed) |-> (res_o.slot_index == '0 && res_o.found_key == '0
                                  && res_o.found_payload == '0))
    else $error("failed result carries data");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the linked record pool
// Drives insert, delete, lookup and spare-mode commands through the start/busy
// handshake, predicts every result from a private copy of the pool, the list
// and the free chain, and checks each strobed result against the oldest expected one.
// ============================================================================
module testbench;

  // The two low bits of the mode field allow one code that names no operation.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned SLOTS = 64;
  // Worst case is a full walk of the pool plus the control steps around it.
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;
  // Quiet cycles allowed before the run is declared hung. The slowest item
  // is a long sender gap followed by a full-pool walk.
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 55;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // Links are one bit wider than a slot number so that null fits.
  typedef logic [6:0] link_t;
  localparam link_t NIL = link_t'(SLOTS);

  // A failed command carries nothing but the failed flag.
  localparam alfl_pkg::res_t NO_MATCH = '{failed: 1'b1, default: '0};

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_e;

  // Two filling phases in a row are sure to run the pool full, and two
  // draining phases in a row bring it back down to empty or close to it.
  localparam phase_e PHASE_PLAN [10] = '{
    PH_FILL, PH_FILL, PH_MIX, PH_DRAIN, PH_DRAIN,
    PH_MIX, PH_FILL, PH_FILL, PH_DRAIN, PH_DRAIN
  };

  // One row of the directed walk: the command, and where the answer is
  // obvious, the result typed in by hand. Other rows use the predictor.
  typedef struct packed {
    alfl_pkg::cmd_t cmd;
    logic           typed_in;
    alfl_pkg::res_t want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [25] = '{
    // Empty list right after reset: both searches fail.
    '{'{alfl_pkg::MODE_LOOKUP, 32'h0000_0000, 64'h0}, 1'b1, NO_MATCH},
    '{'{alfl_pkg::MODE_DELETE, 32'h0000_0000, 64'h0}, 1'b1, NO_MATCH},
    // The spare mode code does nothing and reports failure.
    '{'{MODE_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1, NO_MATCH},
    // Fresh pool hands out slots in order 0, 1, 2, 3.
    '{'{alfl_pkg::MODE_INSERT, 32'h0000_0000, 64'h0}, 1'b1, '{1'b0, 32'h0, 64'h0, 6'd0}},
    '{'{alfl_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
      '{1'b0, 32'h0, 64'h0, 6'd1}},
    '{'{alfl_pkg::MODE_INSERT, 32'h1234_5678, 64'hA5A5_A5A5_A5A5_A5A5}, 1'b1,
      '{1'b0, 32'h0, 64'h0, 6'd2}},
    // Duplicate key: the earlier record must keep winning searches.
    '{'{alfl_pkg::MODE_INSERT, 32'h1234_5678, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b1,
      '{1'b0, 32'h0, 64'h0, 6'd3}},
    '{'{alfl_pkg::MODE_LOOKUP, 32'h1234_5678, 64'hFFFF_0000_FFFF_0000}, 1'b0, '0},
    '{'{alfl_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0}, 1'b0, '0},
    // Absent key on a populated list.
    '{'{alfl_pkg::MODE_LOOKUP, 32'hDEAD_BEEF, 64'h0}, 1'b1, NO_MATCH},
    '{'{alfl_pkg::MODE_DELETE, 32'hDEAD_BEEF, 64'h0}, 1'b1, NO_MATCH},
    // Middle delete, then the duplicate becomes visible and is the tail.
    '{'{alfl_pkg::MODE_DELETE, 32'h1234_5678, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_LOOKUP, 32'h1234_5678, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_DELETE, 32'h1234_5678, 64'h0}, 1'b0, '0},
    // Append after a tail delete: the new tail must link correctly.
    '{'{alfl_pkg::MODE_INSERT, 32'h0000_0007, 64'h0123_4567_89AB_CDEF}, 1'b0, '0},
    '{'{alfl_pkg::MODE_LOOKUP, 32'h0000_0007, 64'h0}, 1'b0, '0},
    // Head deletes down to an empty list.
    '{'{alfl_pkg::MODE_DELETE, 32'h0000_0000, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_DELETE, 32'hFFFF_FFFF, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_DELETE, 32'h0000_0007, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_LOOKUP, 32'h0000_0007, 64'h0}, 1'b1, NO_MATCH},
    // Reuse of a recycled slot from an empty list.
    '{'{alfl_pkg::MODE_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000}, 1'b0, '0},
    '{'{MODE_UNUSED, 32'h0000_0055, 64'h0000_0000_0000_0055}, 1'b1, NO_MATCH},
    '{'{alfl_pkg::MODE_LOOKUP, 32'h8000_0000, 64'h0}, 1'b0, '0},
    '{'{alfl_pkg::MODE_DELETE, 32'h8000_0000, 64'h0}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  alfl_pkg::cmd_t cmd_i = '0;
  logic done_o;
  alfl_pkg::res_t res_o;

  // Private image of the pool: links, stored records, and the list ends.
  link_t slot_links [SLOTS];
  logic [31:0] rec_key [SLOTS];
  logic [63:0] rec_payload [SLOTS];
  link_t free_top;
  link_t list_first;
  link_t list_last;
  int unsigned live_count;
  int unsigned peak_live;
  int unsigned full_hits;

  // Results predicted for accepted items, oldest first.
  alfl_pkg::res_t pending_results [$];

  int unsigned bad_results;
  int unsigned checked_results;
  int unsigned n_insert;
  int unsigned n_delete;
  int unsigned n_lookup;
  int unsigned n_unused;
  int unsigned calm_left;
  int unsigned quiet_cycles;

  array_linked_list_with_free_list u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Walks the list from the head for the first record holding key k. The
  // step bound mirrors the pool size so a broken image cannot loop forever.
  function automatic link_t find_record(input logic [31:0] k, output link_t prev);
    link_t cur;
    int unsigned steps;
    cur = list_first;
    prev = NIL;
    steps = 0;
    while (cur != NIL && steps < SLOTS) begin
      if (rec_key[cur[5:0]] == k) begin
        return cur;
      end
      prev = cur;
      cur = slot_links[cur[5:0]];
      steps++;
    end
    prev = NIL;
    return NIL;
  endfunction

  // Applies one command to the private image and returns the result that
  // the block should strobe for it.
  function automatic alfl_pkg::res_t apply_command(input alfl_pkg::cmd_t c);
    alfl_pkg::res_t r;
    link_t pos;
    link_t prev;
    r = NO_MATCH;
    case (c.mode)
      alfl_pkg::MODE_INSERT: begin
        if (free_top == NIL) begin
          // Pool full: nothing changes.
          full_hits++;
        end else begin
          pos = free_top;
          free_top = slot_links[pos[5:0]];
          rec_key[pos[5:0]] = c.key;
          rec_payload[pos[5:0]] = c.payload;
          slot_links[pos[5:0]] = NIL;
          if (list_last != NIL) begin
            slot_links[list_last[5:0]] = pos;
          end
          list_last = pos;
          if (list_first == NIL) begin
            list_first = pos;
          end
          live_count++;
          if (live_count > peak_live) begin
            peak_live = live_count;
          end
          r = '{1'b0, 32'h0, 64'h0, pos[5:0]};
        end
      end
      alfl_pkg::MODE_DELETE: begin
        pos = find_record(c.key, prev);
        if (pos != NIL) begin
          if (pos == list_first) begin
            list_first = slot_links[pos[5:0]];
            if (list_first == NIL) begin
              list_last = NIL;
            end
          end else begin
            // Bypass the record; on a tail delete the predecessor becomes
            // the tail and inherits the null link.
            slot_links[prev[5:0]] = slot_links[pos[5:0]];
            if (pos == list_last) begin
              list_last = prev;
            end
          end
          slot_links[pos[5:0]] = free_top;
          free_top = pos;
          live_count--;
          r = '{1'b0, 32'h0, 64'h0, pos[5:0]};
        end
      end
      alfl_pkg::MODE_LOOKUP: begin
        pos = find_record(c.key, prev);
        if (pos != NIL) begin
          r = '{1'b0, rec_key[pos[5:0]], rec_payload[pos[5:0]], pos[5:0]};
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sender idle time before the next item: mostly none or a short one, now
  // and then a long pause, and occasional back-to-back runs.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      calm_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 50) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Presents one command and holds it until the block takes it. Called at
  // a rising edge; returns at the edge where the item was accepted, so that
  // start is never dropped and raised again within one time step.
  task automatic send_item(input alfl_pkg::cmd_t c, input logic typed_in,
                           input alfl_pkg::res_t want);
    int unsigned gap;
    alfl_pkg::res_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      cmd_i <= '{mode: 2'($urandom), key: $urandom, payload: {$urandom, $urandom}};
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do begin
      @(posedge clk_i);
    end while (busy);
    // The prediction always runs so the image tracks the block; a typed-in
    // answer, where one is given, is what the result is held to.
    predicted = apply_command(c);
    pending_results.push_back(typed_in ? want : predicted);
    case (c.mode)
      alfl_pkg::MODE_INSERT: n_insert++;
      alfl_pkg::MODE_DELETE: n_delete++;
      alfl_pkg::MODE_LOOKUP: n_lookup++;
      default: n_unused++;
    endcase
  endtask

  task automatic report_bad(input string why, input alfl_pkg::res_t want,
                            input alfl_pkg::res_t got);
    bad_results++;
    if (bad_results <= SHOWN_MISMATCHES) begin
      $display("[%0t] %s: want failed=%0b key=%h payload=%h slot=%0d", $realtime, why,
               want.failed, want.found_key, want.found_payload, want.slot_index);
      $display("          got  failed=%0b key=%h payload=%h slot=%0d",
               got.failed, got.found_key, got.found_payload, got.slot_index);
    end
  endtask

  // Result checker. The strobe lasts one cycle and cannot be stalled, so
  // every edge with done high carries exactly one result to compare.
  always @(posedge clk_i) begin
    alfl_pkg::res_t want;
    if (rst_ni && done_o) begin
      checked_results++;
      if (pending_results.size() == 0) begin
        report_bad("result with no item outstanding", '0, res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.failed !== want.failed || res_o.found_key !== want.found_key ||
            res_o.found_payload !== want.found_payload ||
            res_o.slot_index !== want.slot_index) begin
          report_bad("result mismatch", want, res_o);
        end
      end
    end
  end

  // Hang detector: any acceptance or result strobe counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no progress for %0d cycles", QUIET_LIMIT);
      $display("FAIL array_linked_list_with_free_list");
      $finish;
    end
  end

  initial begin
    logic [31:0] key_pool [16];
    phase_e kind;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned del_pct;
    int unsigned lkp_pct;
    int unsigned pick;
    link_t walk;
    alfl_pkg::cmd_t c;

    bad_results = 0;
    checked_results = 0;
    n_insert = 0;
    n_delete = 0;
    n_lookup = 0;
    n_unused = 0;
    calm_left = 0;
    quiet_cycles = 0;
    live_count = 0;
    peak_live = 0;
    full_hits = 0;

    // Image of the reset state: every slot chained in order on the free
    // list, the last one pointing at null, and the record list empty.
    for (int i = 0; i < SLOTS; i++) begin
      slot_links[i] = link_t'(i + 1);
      rec_key[i] = '0;
      rec_payload[i] = '0;
    end
    free_top = '0;
    list_first = NIL;
    list_last = NIL;

    // A small key set gives duplicates and frequent hits; the extremes of
    // the key range are always in it.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) begin
      key_pool[i] = $urandom;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].cmd, DIRECTED[i].typed_in, DIRECTED[i].want);
    end

    // Random phases. Searches mostly name a key that is on the list, so
    // walks of every length end in a hit; the rest miss or hit by chance.
    for (int ph = 0; ph < 10; ph++) begin
      kind = PHASE_PLAN[ph];
      case (kind)
        PH_FILL: begin
          ins_pct = 90;
          del_pct = 4;
          lkp_pct = 5;
        end
        PH_DRAIN: begin
          ins_pct = 15;
          del_pct = 60;
          lkp_pct = 23;
        end
        default: begin
          ins_pct = 40;
          del_pct = 30;
          lkp_pct = 28;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        c.payload = {$urandom, $urandom};
        if (roll < ins_pct) begin
          c.mode = alfl_pkg::MODE_INSERT;
          c.key = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 15)] : $urandom;
        end else begin
          if (roll < ins_pct + del_pct) begin
            c.mode = alfl_pkg::MODE_DELETE;
          end else if (roll < ins_pct + del_pct + lkp_pct) begin
            c.mode = alfl_pkg::MODE_LOOKUP;
          end else begin
            c.mode = MODE_UNUSED;
          end
          if (live_count != 0 && $urandom_range(0, 99) < 75) begin
            pick = $urandom_range(0, live_count - 1);
            walk = list_first;
            repeat (pick) walk = slot_links[walk[5:0]];
            c.key = rec_key[walk[5:0]];
          end else if ($urandom_range(0, 1) == 0) begin
            c.key = key_pool[$urandom_range(0, 15)];
          end else begin
            c.key = $urandom;
          end
        end
        send_item(c, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // Let any stray strobe show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts, %0d deletes, %0d lookups, %0d spare-mode items; %0d results",
             n_insert, n_delete, n_lookup, n_unused, checked_results);
    $display("Pool ran full on %0d inserts; longest list held %0d records; %0d bad results",
             full_hits, peak_live, bad_results);
    if (bad_results == 0) begin
      $display("PASS array_linked_list_with_free_list");
    end else begin
      $display("FAIL array_linked_list_with_free_list");
    end
    $finish;
  end

endmodule

>>> array_linked_list_with_free_list.f
hdl/alfl_pkg.sv
hdl/alfl_ram.sv
hdl/array_linked_list_with_free_list.sv
verif/testbench.sv
